>>> sv/sins_pkg.sv
// ============================================================================
// Strapdown INS integrator - shared package
// Types, constants, the CORDIC arctangent table and the state saturation
// helper used by the integrator and its arithmetic units.
// ============================================================================
package sins_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int ACCEL_BITS_DEF    = 24;
    localparam int VELOCITY_BITS_DEF = 56;
    localparam int POSITION_BITS_DEF = 64;

    localparam int             GRAVITY_BITS  = 23;
    localparam logic [22:0]    GRAVITY_RESET = 23'd642689;
    localparam int             TIME_BITS     = 16;

    localparam int TRIG_BITS   = 32;
    localparam int MAT_BITS    = 33;
    localparam int MUL_A_BITS  = 64;
    localparam int MUL_B_BITS  = 33;
    localparam int PHASE_BITS  = 32;
    localparam int CORDIC_BITS = 34;
    localparam int CORDIC_STEPS    = 28;
    localparam int CORDIC_IDX_BITS = 5;

    localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN_INIT = 34'sd652032874;
    localparam logic signed [CORDIC_BITS-1:0] Q30_ONE          = 34'sd1073741824;
    localparam logic signed [CORDIC_BITS-1:0] PHASE_HALF_PI    = 34'sd1073741824;
    localparam logic signed [CORDIC_BITS-1:0] PHASE_PI         = 34'sd2147483648;

    localparam int SH_Q30 = 30;
    localparam int SH_T4  = 4;
    localparam int SH_T20 = 20;

    localparam logic signed [64:0] S65_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] S65_MIN = -S65_MAX - 65'sd1;

    typedef enum logic [1:0] {SHIFT_Q30, SHIFT_T4, SHIFT_T20} shift_t;

    typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_SUM} mul_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ANG_GO, ST_ANG_RUN, ST_MUL_GO, ST_MUL_RUN, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {ANG_PITCH, ANG_YAW, ANG_ROLL} ang_t;

    typedef enum logic [4:0] {
        MOP_SPCY, MOP_SPSY, MOP_C00, MOP_C01A, MOP_C01B, MOP_C02A, MOP_C02B,
        MOP_C10, MOP_C11A, MOP_C11B, MOP_C12A, MOP_C12B, MOP_C21, MOP_C22,
        MOP_AN0, MOP_AN1, MOP_AN2, MOP_AE0, MOP_AE1, MOP_AE2,
        MOP_AD0, MOP_AD1, MOP_AD2, MOP_VN, MOP_VE, MOP_VD,
        MOP_PN, MOP_PE, MOP_PD
    } mop_t;

    typedef struct packed {
        logic [63:0] value;
        logic        clip;
    } sat_t;

    function automatic logic [29:0] atan_entry(input logic [CORDIC_IDX_BITS-1:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic sat_t sat_fit(input logic signed [64:0] s, input logic d_pos,
                                     input logic d_neg, input int unsigned bits);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        logic signed [64:0] r;
        sat_t               o;
        hi = (65'sd1 <<< (bits - 1)) - 65'sd1;
        lo = -hi - 65'sd1;
        r  = s;
        if (s > S65_MAX) begin
            r = S65_MAX;
        end else if (s < S65_MIN) begin
            r = S65_MIN;
        end
        o.clip = (d_pos && (r == S65_MAX)) || (d_neg && (r == S65_MIN));
        if (r > hi) begin
            r      = hi;
            o.clip = 1'b1;
        end else if (r < lo) begin
            r      = lo;
            o.clip = 1'b1;
        end
        o.value = r[63:0];
        return o;
    endfunction

endpackage

>>> sv/sins_cordic.sv
// ============================================================================
// Strapdown INS integrator - sine/cosine unit
// Rotation-mode CORDIC, one micro-rotation per cycle, Q2.30 results.
// ============================================================================
module sins_cordic #(
    parameter int ANGLE_BITS = sins_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [ANGLE_BITS-1:0]         angle,
    output logic signed [sins_pkg::TRIG_BITS-1:0] sin_out,
    output logic signed [sins_pkg::TRIG_BITS-1:0] cos_out,
    output logic                                 done
);
    import sins_pkg::*;

    logic                               busy_reg;
    logic                               fin_reg;
    logic                               done_reg;
    logic                               flip_reg;
    logic [CORDIC_IDX_BITS-1:0]         iter_reg;
    logic signed [CORDIC_BITS-1:0]      x_reg, y_reg, z_reg;
    logic signed [TRIG_BITS-1:0]        sin_reg, cos_reg;

    logic signed [CORDIC_BITS-1:0]      phase;
    logic signed [CORDIC_BITS-1:0]      z_init;
    logic                               flip_init;
    logic signed [CORDIC_BITS-1:0]      dx, dy, at;
    logic signed [CORDIC_BITS-1:0]      xf, yf, xc, yc;

    always_comb begin
        phase     = CORDIC_BITS'(angle) <<< (PHASE_BITS - ANGLE_BITS);
        z_init    = phase;
        flip_init = 1'b0;
        if (phase > PHASE_HALF_PI) begin
            z_init    = phase - PHASE_PI;
            flip_init = 1'b1;
        end else if (phase < -PHASE_HALF_PI) begin
            z_init    = phase + PHASE_PI;
            flip_init = 1'b1;
        end
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        at = $signed({4'b0, atan_entry(iter_reg)});
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        xc = (xf > Q30_ONE) ? Q30_ONE : ((xf < -Q30_ONE) ? -Q30_ONE : xf);
        yc = (yf > Q30_ONE) ? Q30_ONE : ((yf < -Q30_ONE) ? -Q30_ONE : yf);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                x_reg    <= CORDIC_GAIN_INIT;
                y_reg    <= '0;
                z_reg    <= z_init;
                flip_reg <= flip_init;
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == CORDIC_IDX_BITS'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                cos_reg  <= xc[TRIG_BITS-1:0];
                sin_reg  <= yc[TRIG_BITS-1:0];
                done_reg <= 1'b1;
            end
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;
    assign done    = done_reg;

endmodule

>>> sv/sins_mul.sv
// ============================================================================
// Strapdown INS integrator - rounding multiplier
// Sign-magnitude product of a 64-bit and a 33-bit operand on one shared
// 32x32 multiplier in two passes, rounded to nearest, ties away from zero.
// ============================================================================
module sins_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [sins_pkg::MUL_A_BITS-1:0] a,
    input  logic signed [sins_pkg::MUL_B_BITS-1:0] b,
    input  sins_pkg::shift_t                      shift,
    output logic [63:0]                           mag,
    output logic                                  neg,
    output logic                                  done
);
    import sins_pkg::*;

    mul_phase_t  phase_reg, phase_next;
    logic [63:0] ma_reg;
    logic [31:0] mb_reg;
    logic        neg_reg;
    shift_t      sh_reg;
    logic [63:0] lo_reg, hi_reg;
    logic [63:0] mag_reg;
    logic        done_reg;

    logic signed [MUL_A_BITS-1:0] a_abs;
    logic signed [MUL_B_BITS-1:0] b_abs;
    logic [31:0]                  lhs;
    logic [63:0]                  prod;
    logic [95:0]                  rnd, full;
    logic [63:0]                  mag_next;

    always_comb begin
        a_abs = a[MUL_A_BITS-1] ? -a : a;
        b_abs = b[MUL_B_BITS-1] ? -b : b;
        lhs   = (phase_reg == MP_HI) ? ma_reg[63:32] : ma_reg[31:0];
        prod  = lhs * mb_reg;
        unique case (sh_reg)
            SHIFT_T4:  rnd = 96'd1 << (SH_T4 - 1);
            SHIFT_T20: rnd = 96'd1 << (SH_T20 - 1);
            default:   rnd = 96'd1 << (SH_Q30 - 1);
        endcase
        full = {hi_reg, 32'b0} + {32'b0, lo_reg} + rnd;
        unique case (sh_reg)
            SHIFT_T4:  mag_next = 64'(full >> SH_T4);
            SHIFT_T20: mag_next = 64'(full >> SH_T20);
            default:   mag_next = 64'(full >> SH_Q30);
        endcase
        phase_next = phase_reg;
        unique case (phase_reg)
            MP_IDLE: if (start) phase_next = MP_LO;
            MP_LO:   phase_next = MP_HI;
            MP_HI:   phase_next = MP_SUM;
            MP_SUM:  phase_next = MP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == MP_IDLE && start) begin
            ma_reg  <= a_abs;
            mb_reg  <= b_abs[31:0];
            neg_reg <= a[MUL_A_BITS-1] ^ b[MUL_B_BITS-1];
            sh_reg  <= shift;
        end
        if (phase_reg == MP_LO) begin
            lo_reg <= prod;
        end
        if (phase_reg == MP_HI) begin
            hi_reg <= prod;
        end
        if (phase_reg == MP_SUM) begin
            mag_reg <= mag_next;
        end
    end

    assign mag  = mag_reg;
    assign neg  = neg_reg;
    assign done = done_reg;

endmodule

>>> sv/strapdown_ins_integrator.sv
// ============================================================================
// Strapdown INS integrator - top level
// Rotates body acceleration into NED, removes gravity and integrates velocity
// and position in fixed point, one step per input item.
// ============================================================================
// Usage:
//   s_axis carries one step: tdata holds accel x/y/z, roll, pitch, yaw and
//   time step; tuser[0] is the clear command. m_axis returns one item per
//   input: position and velocity after the step, with applied and saturated
//   flags in tuser. cfg_wr_en/cfg_wr_data write the gravity register.
//   An integrating step runs from acceptance to the result register:
//   three CORDIC runs on the one sine/cosine unit, then 29 products on
//   the one two-pass multiplier. A clear or a zero time step skips both
//   phases and goes straight to the result. s_axis_tready is high only
//   while no step is in progress, so one item is processed at a time.
//   A new item is accepted while the previous result still waits in the
//   output register; a finished step holds until that register is free,
//   so a stalled receiver stalls the block without losing an item.
//   Reset zeroes velocity and position, restores gravity to its default
//   and empties the output register.
// ============================================================================
module strapdown_ins_integrator #(
    parameter int ANGLE_BITS    = sins_pkg::ANGLE_BITS_DEF,
    parameter int ACCEL_BITS    = sins_pkg::ACCEL_BITS_DEF,
    parameter int VELOCITY_BITS = sins_pkg::VELOCITY_BITS_DEF,
    parameter int POSITION_BITS = sins_pkg::POSITION_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [sins_pkg::GRAVITY_BITS-1:0]      cfg_wr_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // accel_x, accel_y, accel_z, roll, pitch, yaw, time_step
    input  logic [((3*ACCEL_BITS+3*ANGLE_BITS+sins_pkg::TIME_BITS+7)/8)*8-1:0]
                                                   s_axis_tdata,
    // command
    input  logic [0:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // north/east/down_position, north/east/down_velocity
    output logic [((3*POSITION_BITS+3*VELOCITY_BITS+7)/8)*8-1:0] m_axis_tdata,
    // applied, saturated
    output logic [1:0]                             m_axis_tuser
);
    import sins_pkg::*;

    localparam int M_DATA_BITS = ((3*POSITION_BITS+3*VELOCITY_BITS+7)/8)*8;
    localparam int NED_BITS    = ((ACCEL_BITS > GRAVITY_BITS) ? ACCEL_BITS : GRAVITY_BITS) + 4;
    localparam int AY_LO       = ACCEL_BITS;
    localparam int AZ_LO       = 2*ACCEL_BITS;
    localparam int ROLL_LO     = 3*ACCEL_BITS;
    localparam int PITCH_LO    = 3*ACCEL_BITS + ANGLE_BITS;
    localparam int YAW_LO      = 3*ACCEL_BITS + 2*ANGLE_BITS;
    localparam int DT_LO       = 3*ACCEL_BITS + 3*ANGLE_BITS;

    state_t state_reg, state_next;
    ang_t   ang_reg;
    mop_t   step_reg;

    logic [GRAVITY_BITS-1:0]          gravity_reg;
    logic signed [ACCEL_BITS-1:0]     ax_reg, ay_reg, az_reg;
    logic signed [ANGLE_BITS-1:0]     roll_reg, pitch_reg, yaw_reg;
    logic [TIME_BITS-1:0]             dt_reg;
    logic signed [TRIG_BITS-1:0]      sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [MAT_BITS-1:0]       spcy_reg, spsy_reg, c00_reg, c01_reg, c02_reg;
    logic signed [MAT_BITS-1:0]       c10_reg, c11_reg, c12_reg, c21_reg, c22_reg;
    logic signed [NED_BITS-1:0]       an_reg, ae_reg, ad_reg;
    logic signed [VELOCITY_BITS-1:0]  vn_reg, ve_reg, vd_reg;
    logic signed [POSITION_BITS-1:0]  pn_reg, pe_reg, pd_reg;
    logic                             applied_reg, clip_reg;
    logic                             m_tvalid_reg;
    logic [M_DATA_BITS-1:0]           m_tdata_reg;
    logic [1:0]                       m_tuser_reg;

    logic                             in_accept;
    logic [TIME_BITS-1:0]             dt_in;
    logic                             cordic_start, cordic_done, mul_start, mul_done;
    logic                             out_load;
    logic signed [ANGLE_BITS-1:0]     cordic_angle;
    logic signed [TRIG_BITS-1:0]      cordic_sin, cordic_cos;
    logic signed [MUL_A_BITS-1:0]     mul_a;
    logic signed [MUL_B_BITS-1:0]     mul_b;
    shift_t                           mul_shift;
    logic [63:0]                      mul_mag;
    logic                             mul_neg;
    logic                             wb_sub;
    logic signed [64:0]               wb_base;
    logic                             dneg, d_pos, d_neg;
    logic signed [64:0]               mag65, delta65, sum65, grav65;
    int unsigned                      sat_bits;
    sat_t                             sat;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign dt_in         = s_axis_tdata[DT_LO +: TIME_BITS];

    always_comb begin
        unique case (ang_reg)
            ANG_YAW:  cordic_angle = yaw_reg;
            ANG_ROLL: cordic_angle = roll_reg;
            default:  cordic_angle = pitch_reg;
        endcase
    end

    sins_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .sin_out (cordic_sin),
        .cos_out (cordic_cos),
        .done    (cordic_done)
    );

    sins_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .shift   (mul_shift),
        .mag     (mul_mag),
        .neg     (mul_neg),
        .done    (mul_done)
    );

    always_comb begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        mul_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_axis_tuser[0] || dt_in == '0) ? ST_FINISH : ST_ANG_GO;
                end
            end
            ST_ANG_GO: begin
                cordic_start = 1'b1;
                state_next   = ST_ANG_RUN;
            end
            ST_ANG_RUN: begin
                if (cordic_done) begin
                    state_next = (ang_reg == ANG_ROLL) ? ST_MUL_GO : ST_ANG_GO;
                end
            end
            ST_MUL_GO: begin
                mul_start  = 1'b1;
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
                if (mul_done) begin
                    state_next = (step_reg == MOP_PD) ? ST_FINISH : ST_MUL_GO;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_shift = SHIFT_Q30;
        wb_sub    = 1'b0;
        wb_base   = '0;
        unique case (step_reg)
            MOP_SPCY: begin mul_a = 64'(sp_reg); mul_b = 33'(cy_reg); end
            MOP_SPSY: begin mul_a = 64'(sp_reg); mul_b = 33'(sy_reg); end
            MOP_C00:  begin mul_a = 64'(cp_reg); mul_b = 33'(cy_reg); end
            MOP_C01A: begin mul_a = 64'(sr_reg); mul_b = spcy_reg; end
            MOP_C01B: begin
                mul_a = 64'(cr_reg); mul_b = 33'(sy_reg);
                wb_sub = 1'b1; wb_base = 65'(c01_reg);
            end
            MOP_C02A: begin mul_a = 64'(cr_reg); mul_b = spcy_reg; end
            MOP_C02B: begin
                mul_a = 64'(sr_reg); mul_b = 33'(sy_reg); wb_base = 65'(c02_reg);
            end
            MOP_C10:  begin mul_a = 64'(cp_reg); mul_b = 33'(sy_reg); end
            MOP_C11A: begin mul_a = 64'(sr_reg); mul_b = spsy_reg; end
            MOP_C11B: begin
                mul_a = 64'(cr_reg); mul_b = 33'(cy_reg); wb_base = 65'(c11_reg);
            end
            MOP_C12A: begin mul_a = 64'(cr_reg); mul_b = spsy_reg; end
            MOP_C12B: begin
                mul_a = 64'(sr_reg); mul_b = 33'(cy_reg);
                wb_sub = 1'b1; wb_base = 65'(c12_reg);
            end
            MOP_C21:  begin mul_a = 64'(sr_reg); mul_b = 33'(cp_reg); end
            MOP_C22:  begin mul_a = 64'(cr_reg); mul_b = 33'(cp_reg); end
            MOP_AN0:  begin mul_a = 64'(ax_reg); mul_b = c00_reg; end
            MOP_AN1:  begin mul_a = 64'(ay_reg); mul_b = c01_reg; wb_base = 65'(an_reg); end
            MOP_AN2:  begin mul_a = 64'(az_reg); mul_b = c02_reg; wb_base = 65'(an_reg); end
            MOP_AE0:  begin mul_a = 64'(ax_reg); mul_b = c10_reg; end
            MOP_AE1:  begin mul_a = 64'(ay_reg); mul_b = c11_reg; wb_base = 65'(ae_reg); end
            MOP_AE2:  begin mul_a = 64'(az_reg); mul_b = c12_reg; wb_base = 65'(ae_reg); end
            MOP_AD0:  begin mul_a = 64'(ax_reg); mul_b = 33'(sp_reg); wb_sub = 1'b1; end
            MOP_AD1:  begin mul_a = 64'(ay_reg); mul_b = c21_reg; wb_base = 65'(ad_reg); end
            MOP_AD2:  begin mul_a = 64'(az_reg); mul_b = c22_reg; wb_base = 65'(ad_reg); end
            MOP_VN: begin
                mul_a = 64'(an_reg); mul_b = $signed({17'b0, dt_reg});
                mul_shift = SHIFT_T4; wb_base = 65'(vn_reg);
            end
            MOP_VE: begin
                mul_a = 64'(ae_reg); mul_b = $signed({17'b0, dt_reg});
                mul_shift = SHIFT_T4; wb_base = 65'(ve_reg);
            end
            MOP_VD: begin
                mul_a = 64'(ad_reg); mul_b = $signed({17'b0, dt_reg});
                mul_shift = SHIFT_T4; wb_base = 65'(vd_reg);
            end
            MOP_PN: begin
                mul_a = 64'(vn_reg); mul_b = $signed({17'b0, dt_reg});
                mul_shift = SHIFT_T20; wb_base = 65'(pn_reg);
            end
            MOP_PE: begin
                mul_a = 64'(ve_reg); mul_b = $signed({17'b0, dt_reg});
                mul_shift = SHIFT_T20; wb_base = 65'(pe_reg);
            end
            MOP_PD: begin
                mul_a = 64'(vd_reg); mul_b = $signed({17'b0, dt_reg});
                mul_shift = SHIFT_T20; wb_base = 65'(pd_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        dneg     = mul_neg ^ wb_sub;
        mag65    = $signed({1'b0, mul_mag});
        delta65  = dneg ? -mag65 : mag65;
        sum65    = wb_base + delta65;
        grav65   = sum65 - $signed({42'b0, gravity_reg});
        d_pos    = (mul_mag != '0) && !dneg;
        d_neg    = (mul_mag != '0) && dneg;
        sat_bits = (step_reg == MOP_PN || step_reg == MOP_PE || step_reg == MOP_PD)
                   ? POSITION_BITS : VELOCITY_BITS;
        sat      = sat_fit(sum65, d_pos, d_neg, sat_bits);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gravity_reg  <= GRAVITY_RESET;
            m_tvalid_reg <= 1'b0;
            vn_reg <= '0; ve_reg <= '0; vd_reg <= '0;
            pn_reg <= '0; pe_reg <= '0; pd_reg <= '0;
            applied_reg  <= 1'b0;
            clip_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                gravity_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_accept) begin
                clip_reg    <= 1'b0;
                applied_reg <= s_axis_tuser[0] || (dt_in != '0);
                if (s_axis_tuser[0]) begin
                    vn_reg <= '0; ve_reg <= '0; vd_reg <= '0;
                    pn_reg <= '0; pe_reg <= '0; pd_reg <= '0;
                end
            end
            if (state_reg == ST_MUL_RUN && mul_done) begin
                unique case (step_reg)
                    MOP_VN: begin vn_reg <= sat.value[VELOCITY_BITS-1:0]; clip_reg <= clip_reg | sat.clip; end
                    MOP_VE: begin ve_reg <= sat.value[VELOCITY_BITS-1:0]; clip_reg <= clip_reg | sat.clip; end
                    MOP_VD: begin vd_reg <= sat.value[VELOCITY_BITS-1:0]; clip_reg <= clip_reg | sat.clip; end
                    MOP_PN: begin pn_reg <= sat.value[POSITION_BITS-1:0]; clip_reg <= clip_reg | sat.clip; end
                    MOP_PE: begin pe_reg <= sat.value[POSITION_BITS-1:0]; clip_reg <= clip_reg | sat.clip; end
                    MOP_PD: begin pd_reg <= sat.value[POSITION_BITS-1:0]; clip_reg <= clip_reg | sat.clip; end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ax_reg    <= s_axis_tdata[0 +: ACCEL_BITS];
            ay_reg    <= s_axis_tdata[AY_LO +: ACCEL_BITS];
            az_reg    <= s_axis_tdata[AZ_LO +: ACCEL_BITS];
            roll_reg  <= s_axis_tdata[ROLL_LO +: ANGLE_BITS];
            pitch_reg <= s_axis_tdata[PITCH_LO +: ANGLE_BITS];
            yaw_reg   <= s_axis_tdata[YAW_LO +: ANGLE_BITS];
            dt_reg    <= dt_in;
            ang_reg   <= ANG_PITCH;
            step_reg  <= MOP_SPCY;
        end
        if (state_reg == ST_ANG_RUN && cordic_done) begin
            unique case (ang_reg)
                ANG_PITCH: begin sp_reg <= cordic_sin; cp_reg <= cordic_cos; ang_reg <= ANG_YAW; end
                ANG_YAW:   begin sy_reg <= cordic_sin; cy_reg <= cordic_cos; ang_reg <= ANG_ROLL; end
                default:   begin sr_reg <= cordic_sin; cr_reg <= cordic_cos; end
            endcase
        end
        if (state_reg == ST_MUL_RUN && mul_done) begin
            if (step_reg != MOP_PD) begin
                step_reg <= mop_t'(step_reg + 5'd1);
            end
            unique case (step_reg)
                MOP_SPCY: spcy_reg <= sum65[MAT_BITS-1:0];
                MOP_SPSY: spsy_reg <= sum65[MAT_BITS-1:0];
                MOP_C00:  c00_reg  <= sum65[MAT_BITS-1:0];
                MOP_C01A, MOP_C01B: c01_reg <= sum65[MAT_BITS-1:0];
                MOP_C02A, MOP_C02B: c02_reg <= sum65[MAT_BITS-1:0];
                MOP_C10:  c10_reg  <= sum65[MAT_BITS-1:0];
                MOP_C11A, MOP_C11B: c11_reg <= sum65[MAT_BITS-1:0];
                MOP_C12A, MOP_C12B: c12_reg <= sum65[MAT_BITS-1:0];
                MOP_C21:  c21_reg  <= sum65[MAT_BITS-1:0];
                MOP_C22:  c22_reg  <= sum65[MAT_BITS-1:0];
                MOP_AN0, MOP_AN1, MOP_AN2: an_reg <= sum65[NED_BITS-1:0];
                MOP_AE0, MOP_AE1, MOP_AE2: ae_reg <= sum65[NED_BITS-1:0];
                MOP_AD0, MOP_AD1:          ad_reg <= sum65[NED_BITS-1:0];
                MOP_AD2:                   ad_reg <= grav65[NED_BITS-1:0];
                default: ;
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= M_DATA_BITS'({vd_reg, ve_reg, vn_reg, pd_reg, pe_reg, pn_reg});
            m_tuser_reg <= {clip_reg, applied_reg};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    a_mul_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL_RUN))
        else $error("multiplier result outside multiply phase");

    a_cordic_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_ANG_RUN))
        else $error("sine/cosine result outside angle phase");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_axis_tuser[0]) |=>
            (vn_reg == '0 && vd_reg == '0 && pn_reg == '0 && pd_reg == '0 && !clip_reg))
        else $error("clear item left state or clip flag set");

    a_load_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_axis_tvalid && state_reg == ST_IDLE))
        else $error("finished item not presented");

endmodule

>>> tb/tb_strapdown_ins_integrator.sv
`timescale 1ns / 100ps
// ============================================================================
// Strapdown INS integrator - testbench
// Drives integration steps, clears and zero time steps through the input
// stream, predicts position and velocity with an independent fixed-point
// model of the rotation and integration, and checks every result item.
// ============================================================================
module tb_strapdown_ins_integrator;
    import sins_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam bit  CMD_STEP    = 1'b0;
    localparam bit  CMD_CLEAR   = 1'b1;
    localparam longint I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit              command;
        logic [23:0]     ax, ay, az;
        logic [15:0]     roll, pitch, yaw;
        logic [15:0]     dt;
    } step_in_t;

    typedef struct {
        logic [63:0] pn, pe, pd;
        logic [55:0] vn, ve, vd;
        bit          applied, saturated;
    } nav_state_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [22:0]   cfg_wr_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata = '0;
    logic [0:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [359:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;

    nav_state_t    nav_expected[$];
    longint        vel_n, vel_e, vel_d, pos_n, pos_e, pos_d;
    logic [22:0]   gravity_reg;
    int            mismatches = 0;
    int            cycles = 0;
    bit            no_idle = 1'b0;

    longint atan_lut[28] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005
    };

    strapdown_ins_integrator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint round_mul(input longint a, input longint b, input int s);
        logic [63:0] ma, mb, hi, lo, r;
        longint      res;
        ma  = (a < 0) ? 64'(-a) : 64'(a);
        mb  = ((b < 0) ? 64'(-b) : 64'(b)) & 64'hFFFF_FFFF;
        hi  = (ma >> 32) * mb;
        lo  = (ma & 64'hFFFF_FFFF) * mb + (64'd1 << (s - 1));
        r   = ((s == 32) ? hi : (hi << (32 - s))) + (lo >> s);
        if (r > 64'(I64_MAX)) r = 64'(I64_MAX);
        res = longint'(r);
        return ((a < 0) != (b < 0)) ? -res : res;
    endfunction

    function automatic longint clip_add(input longint a, input longint b, input int bits,
                                        inout bit clip);
        logic signed [64:0] sa, sb, sum, hi, lo, mx, mn;
        sa  = 65'(a);
        sb  = 65'(b);
        mx  = 65'(I64_MAX);
        mn  = -mx - 65'sd1;
        sum = sa + sb;
        hi  = (65'sd1 <<< (bits - 1)) - 65'sd1;
        lo  = -hi - 65'sd1;
        if (sum > mx) sum = mx;
        else if (sum < mn) sum = mn;
        if (sum > hi) begin
            clip = 1'b1;
            return longint'(hi);
        end
        if (sum < lo) begin
            clip = 1'b1;
            return longint'(lo);
        end
        if ((b > 0 && sum == mx) || (b < 0 && sum == mn)) clip = 1'b1;
        return longint'(sum);
    endfunction

    function automatic void angle_trig(input logic [15:0] ang, output longint sn,
                                       output longint cs);
        longint p, x, y, z, dx, dy;
        bit     flip;
        p    = longint'($signed({ang, 16'h0000}));
        x    = 652032874;
        y    = 0;
        flip = 1'b0;
        if (p > 64'sh40000000) begin
            p    = p - 64'sh80000000;
            flip = 1'b1;
        end else if (p < -64'sh40000000) begin
            p    = p + 64'sh80000000;
            flip = 1'b1;
        end
        z = p;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_lut[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_lut[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        if (x > 64'sd1073741824) x = 64'sd1073741824;
        if (x < -64'sd1073741824) x = -64'sd1073741824;
        if (y > 64'sd1073741824) y = 64'sd1073741824;
        if (y < -64'sd1073741824) y = -64'sd1073741824;
        sn = y;
        cs = x;
    endfunction

    function automatic nav_state_t advance_nav(input step_in_t it);
        nav_state_t o;
        longint sr, cr, sp, cp, sy, cy, spcy, spsy, t, ax, ay, az, an, ae, ad;
        longint c00, c01, c02, c10, c11, c12, c20, c21, c22;
        bit     clip;
        clip      = 1'b0;
        o.applied = 1'b0;
        if (it.command == CMD_CLEAR) begin
            vel_n = 0; vel_e = 0; vel_d = 0;
            pos_n = 0; pos_e = 0; pos_d = 0;
            o.applied = 1'b1;
        end else if (it.dt != 0) begin
            ax = longint'($signed(it.ax));
            ay = longint'($signed(it.ay));
            az = longint'($signed(it.az));
            t  = longint'(it.dt);
            angle_trig(it.roll, sr, cr);
            angle_trig(it.pitch, sp, cp);
            angle_trig(it.yaw, sy, cy);
            spcy = round_mul(sp, cy, 30);
            spsy = round_mul(sp, sy, 30);
            c00  = round_mul(cp, cy, 30);
            c01  = round_mul(sr, spcy, 30) - round_mul(cr, sy, 30);
            c02  = round_mul(cr, spcy, 30) + round_mul(sr, sy, 30);
            c10  = round_mul(cp, sy, 30);
            c11  = round_mul(sr, spsy, 30) + round_mul(cr, cy, 30);
            c12  = round_mul(cr, spsy, 30) - round_mul(sr, cy, 30);
            c20  = -sp;
            c21  = round_mul(sr, cp, 30);
            c22  = round_mul(cr, cp, 30);
            an = round_mul(ax, c00, 30) + round_mul(ay, c01, 30) + round_mul(az, c02, 30);
            ae = round_mul(ax, c10, 30) + round_mul(ay, c11, 30) + round_mul(az, c12, 30);
            ad = round_mul(ax, c20, 30) + round_mul(ay, c21, 30) + round_mul(az, c22, 30)
                 - longint'(gravity_reg);
            vel_n = clip_add(vel_n, round_mul(an, t, 4), 56, clip);
            vel_e = clip_add(vel_e, round_mul(ae, t, 4), 56, clip);
            vel_d = clip_add(vel_d, round_mul(ad, t, 4), 56, clip);
            pos_n = clip_add(pos_n, round_mul(vel_n, t, 20), 64, clip);
            pos_e = clip_add(pos_e, round_mul(vel_e, t, 20), 64, clip);
            pos_d = clip_add(pos_d, round_mul(vel_d, t, 20), 64, clip);
            o.applied = 1'b1;
        end
        o.pn = pos_n; o.pe = pos_e; o.pd = pos_d;
        o.vn = vel_n[55:0]; o.ve = vel_e[55:0]; o.vd = vel_d[55:0];
        o.saturated = clip;
        return o;
    endfunction

    task automatic send_step(input step_in_t it);
        @(negedge aclk);
        if (!no_idle && $urandom_range(99) < 38) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {it.dt, it.yaw, it.pitch, it.roll, it.az, it.ay, it.ax};
        s_axis_tuser  = it.command;
        do @(posedge aclk); while (!s_axis_tready);
        nav_expected.push_back(advance_nav(it));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        wait (nav_expected.size() == 0);
        repeat (250) @(negedge aclk);
    endtask

    task automatic write_gravity(input logic [22:0] g);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = g;
        gravity_reg = g;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic step_in_t make_step(input bit cmd, input int ax, input int ay,
                                           input int az, input int r, input int p,
                                           input int y, input int dt);
        step_in_t it;
        it.command = cmd;
        it.ax = 24'(ax); it.ay = 24'(ay); it.az = 24'(az);
        it.roll = 16'(r); it.pitch = 16'(p); it.yaw = 16'(y);
        it.dt = 16'(dt);
        return it;
    endfunction

    function automatic step_in_t random_step();
        step_in_t it;
        int       k;
        it.command = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_STEP;
        it.ax = 24'($urandom); it.ay = 24'($urandom); it.az = 24'($urandom);
        it.roll = 16'($urandom); it.pitch = 16'($urandom); it.yaw = 16'($urandom);
        k = $urandom_range(99);
        if (k < 5) it.dt = '0;
        else if (k < 15) it.dt = 16'hFFFF;
        else if (k < 60) it.dt = 16'($urandom_range(4096, 1));
        else it.dt = 16'($urandom);
        if ($urandom_range(9) == 0) it.ax = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        if ($urandom_range(9) == 0) it.az = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        if ($urandom_range(7) == 0) it.pitch = $urandom_range(1) ? 16'h4000 : 16'hC000;
        if ($urandom_range(7) == 0) it.roll = 16'h8000;
        return it;
    endfunction

    task automatic test_idle_state();
        send_step(make_step(CMD_STEP, 1000, -1000, 50000, 0, 0, 0, 0));
        send_step(make_step(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_level_gravity();
        send_step(make_step(CMD_STEP, 0, 0, 642689, 0, 0, 0, 1024));
        send_step(make_step(CMD_STEP, 0, 0, 0, 0, 0, 0, 65535));
        send_step(make_step(CMD_STEP, 65536, 0, 0, 0, 0, 0, 1));
        send_step(make_step(CMD_STEP, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_angles();
        send_step(make_step(CMD_STEP, 100000, 200000, 300000, -32768, 0, 0, 500));
        send_step(make_step(CMD_STEP, 100000, 200000, 300000, 32767, 32767, 32767, 500));
        send_step(make_step(CMD_STEP, 100000, 200000, 300000, 0, -32768, 16384, 500));
        send_step(make_step(CMD_STEP, 100000, 200000, 300000, 16384, -16384, -32768, 500));
        send_step(make_step(CMD_STEP, 100000, 200000, 300000, -16385, 16385, -16384, 500));
        send_step(make_step(CMD_STEP, -300000, 1, -1, 8192, -8192, 24576, 777));
    endtask

    task automatic test_accel_extremes();
        send_step(make_step(CMD_STEP, 8388607, 8388607, 8388607, 5461, 2730, 1365, 65535));
        send_step(make_step(CMD_STEP, -8388608, -8388608, -8388608, 0, 0, 0, 65535));
        send_step(make_step(CMD_STEP, 8388607, -8388608, 8388607, -5461, 32767, 0, 65535));
        send_step(make_step(CMD_STEP, -1, -1, -1, -1, -1, -1, 1));
        send_step(make_step(CMD_CLEAR, 8388607, 8388607, 8388607, 1, 1, 1, 65535));
    endtask

    task automatic test_gravity_settings();
        write_gravity(23'd0);
        send_step(make_step(CMD_STEP, 0, 0, 12345, 0, 0, 0, 4000));
        write_gravity(23'h7FFFFF);
        send_step(make_step(CMD_STEP, 0, 0, -8388608, 0, 0, 0, 65535));
        send_step(make_step(CMD_STEP, 3, 5, 7, 100, 200, 300, 2));
        write_gravity(GRAVITY_RESET);
    endtask

    task automatic test_random_flight();
        for (int n = 0; n < 1100; n++) begin
            no_idle = (n >= 300 && n < 420);
            if (n == 550) drain();
            if (n == 700) write_gravity(23'($urandom));
            if (n == 900) write_gravity(GRAVITY_RESET);
            send_step(random_step());
        end
        no_idle = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= no_idle || ($urandom_range(99) >= 38);
    end

    always @(posedge aclk) begin
        nav_state_t e;
        logic [359:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (nav_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
                e    = nav_expected.pop_front();
                want = {e.vd, e.ve, e.vn, e.pd, e.pe, e.pn};
                if (m_axis_tdata !== want || m_axis_tuser !== {e.saturated, e.applied}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp data %h user %b, got data %h user %b",
                                 $realtime, want, {e.saturated, e.applied},
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        vel_n = 0; vel_e = 0; vel_d = 0;
        pos_n = 0; pos_e = 0; pos_d = 0;
        gravity_reg = GRAVITY_RESET;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        test_idle_state();
        test_level_gravity();
        test_angles();
        test_accel_extremes();
        test_gravity_settings();
        test_random_flight();
        drain();
        if (mismatches == 0 && nav_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
